// ===== design/bmc_pkg.sv =====
`default_nettype none
package bmc_pkg;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 16;

  localparam logic [CfgIndexBits-1:0] REG_CLICK_MIN   = 3'd0;
  localparam logic [CfgIndexBits-1:0] REG_CLICK_MAX   = 3'd1;
  localparam logic [CfgIndexBits-1:0] REG_LONG_MIN    = 3'd2;
  localparam logic [CfgIndexBits-1:0] REG_LONG_MAX    = 3'd3;
  localparam logic [CfgIndexBits-1:0] REG_GAP_MIN     = 3'd4;
  localparam logic [CfgIndexBits-1:0] REG_GAP_MAX     = 3'd5;
  localparam logic [CfgIndexBits-1:0] REG_CLICK_LIMIT = 3'd6;

  localparam logic [15:0] RST_CLICK_MIN   = 16'd50;
  localparam logic [15:0] RST_CLICK_MAX   = 16'd500;
  localparam logic [15:0] RST_LONG_MIN    = 16'd1000;
  localparam logic [15:0] RST_LONG_MAX    = 16'd5000;
  localparam logic [15:0] RST_GAP_MIN     = 16'd50;
  localparam logic [15:0] RST_GAP_MAX     = 16'd400;
  localparam logic [7:0]  RST_CLICK_LIMIT = 8'd3;

  localparam logic [1:0] EV_SINGLE = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_TRIPLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [15:0] click_min;
    logic [15:0] click_max;
    logic [15:0] long_min;
    logic [15:0] long_max;
    logic [15:0] gap_min;
    logic [15:0] gap_max;
    logic [7:0]  click_limit;
  } bmc_cfg_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] code;
  } bmc_event_t;

endpackage
`default_nettype wire

// ===== design/bmc_cfg_regs.sv =====
`default_nettype none
module bmc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [bmc_pkg::CfgIndexBits-1:0]  wr_index,
  input  wire logic [bmc_pkg::CfgDataBits-1:0]   wr_data,
  output bmc_pkg::bmc_cfg_t                      cfg
);
  import bmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_min   <= RST_CLICK_MIN;
      cfg.click_max   <= RST_CLICK_MAX;
      cfg.long_min    <= RST_LONG_MIN;
      cfg.long_max    <= RST_LONG_MAX;
      cfg.gap_min     <= RST_GAP_MIN;
      cfg.gap_max     <= RST_GAP_MAX;
      cfg.click_limit <= RST_CLICK_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_CLICK_MIN:   cfg.click_min   <= wr_data;
        REG_CLICK_MAX:   cfg.click_max   <= wr_data;
        REG_LONG_MIN:    cfg.long_min    <= wr_data;
        REG_LONG_MAX:    cfg.long_max    <= wr_data;
        REG_GAP_MIN:     cfg.gap_min     <= wr_data;
        REG_GAP_MAX:     cfg.gap_max     <= wr_data;
        REG_CLICK_LIMIT: cfg.click_limit <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/bmc_fsm.sv =====
`default_nettype none
module bmc_fsm #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          pressed,
  input  wire bmc_pkg::bmc_cfg_t cfg,
  output bmc_pkg::bmc_event_t ev
);
  import bmc_pkg::*;

  localparam int CmpBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_PAUSE = 3'b010,
    PH_NEXT  = 3'b100
  } phase_t;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [7:0]            click_count, click_count_next;

  logic [COUNT_BITS-1:0] tick_inc;
  logic [CmpBits-1:0]    tick_ext, inc_ext;
  logic [CmpBits-1:0]    click_min_x, click_max_x, long_min_x, long_max_x;
  logic [CmpBits-1:0]    gap_min_x, gap_max_x;
  logic                  gap_ok;

  assign tick_inc    = (&tick_count) ? tick_count : tick_count + 1'b1;
  assign tick_ext    = CmpBits'(tick_count);
  assign inc_ext     = CmpBits'(tick_inc);
  assign click_min_x = CmpBits'(cfg.click_min);
  assign click_max_x = CmpBits'(cfg.click_max);
  assign long_min_x  = CmpBits'(cfg.long_min);
  assign long_max_x  = CmpBits'(cfg.long_max);
  assign gap_min_x   = CmpBits'(cfg.gap_min);
  assign gap_max_x   = CmpBits'(cfg.gap_max);
  assign gap_ok      = (tick_ext >= gap_min_x) && (tick_ext <= gap_max_x);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    click_count_next = click_count;
    ev.emit          = 1'b0;
    ev.code          = EV_SINGLE;
    case (phase)
      PH_FIRST: begin
        if (pressed) begin
          tick_count_next = tick_inc;
        end else if (tick_ext > click_min_x) begin
          if (tick_ext < click_max_x) begin
            phase_next       = PH_PAUSE;
            tick_count_next  = '0;
            click_count_next = 8'd1;
          end else if (tick_ext > click_max_x) begin
            if ((tick_ext >= long_min_x) && (tick_ext <= long_max_x)) begin
              ev.emit = 1'b1;
              ev.code = EV_LONG;
            end
            tick_count_next = '0;
          end
        end else begin
          tick_count_next = '0;
        end
      end
      PH_PAUSE: begin
        if (!pressed) begin
          tick_count_next = tick_inc;
          if (inc_ext >= gap_max_x) begin
            if ((click_count >= 8'd1) && (click_count <= 8'd3)) begin
              ev.emit = 1'b1;
              ev.code = 2'(click_count - 8'd1);
            end
            phase_next       = PH_FIRST;
            tick_count_next  = '0;
            click_count_next = '0;
          end
        end else if (gap_ok && (click_count <= cfg.click_limit)) begin
          phase_next       = PH_NEXT;
          tick_count_next  = '0;
          click_count_next = click_count + 8'd1;
        end else begin
          phase_next       = PH_FIRST;
          tick_count_next  = '0;
          click_count_next = '0;
        end
      end
      PH_NEXT: begin
        if (pressed) begin
          tick_count_next = tick_inc;
        end else if (gap_ok) begin
          phase_next      = PH_PAUSE;
          tick_count_next = '0;
        end else begin
          phase_next       = PH_FIRST;
          tick_count_next  = '0;
          click_count_next = '0;
        end
      end
      default: begin
        phase_next       = PH_FIRST;
        tick_count_next  = '0;
        click_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      tick_count  <= '0;
      click_count <= '0;
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      click_count <= click_count_next;
    end
  end

  // click sequence end always lands back in an empty first-press state
  a_click_end_restarts: assert property (@(posedge clk) disable iff (rst)
    step && ev.emit && (ev.code != EV_LONG)
      |=> (phase == PH_FIRST) && (tick_count == '0) && (click_count == '0))
    else $error("click event did not restart the sequence");

  a_long_from_first: assert property (@(posedge clk) disable iff (rst)
    step && ev.emit && (ev.code == EV_LONG) |-> (phase == PH_FIRST) && !pressed)
    else $error("long press reported outside first press");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_count) && $stable(click_count))
    else $error("state moved without a word");

endmodule
`default_nettype wire

// ===== design/button_multi_click_classifier_core.sv =====
// an accepted input word is held in the input register; its event is then registered in the event
// register on the master side; throughput: one tick word per cycle while no event waits on m_tready,
// set by the state update between the input register and the event register
// an event waiting on m_tready holds the next tick in the input register and stalls s_tready
// reset: rst is synchronous, clears the state machine and restores config defaults
`default_nettype none
module button_multi_click_classifier_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [0] pressed
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [7:0]                            m_tdata,   // [1:0] event_code
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bmc_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [bmc_pkg::CfgDataBits-1:0]  cfg_data
);
  import bmc_pkg::*;

  bmc_cfg_t   cfg;
  bmc_event_t ev;
  logic       in_valid;
  logic       in_pressed;
  logic [1:0] out_code;
  logic       process;
  logic       s_accept;

  assign cfg_ready = 1'b1;
  assign process   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || process;
  assign s_accept  = s_tvalid && s_tready;
  assign m_tdata   = {6'b0, out_code};

  bmc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bmc_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (process),
    .pressed (in_pressed),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_pressed <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process) begin
      m_tvalid <= ev.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_code <= ev.code;
    end
  end

  // input side only stalls while a word waits and the event register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked event");

  a_no_event_loss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_code))
    else $error("pending event overwritten");

endmodule
`default_nettype wire
